// File: src/nrpe_pkg.sv
// Shared constants and helpers for the RMC position extractor.
package nrpe_pkg;

  localparam int unsigned LatW   = 27;
  localparam int unsigned LonW   = 30;
  localparam int unsigned FracW  = 3;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned Pow10W = 24;

  localparam logic [LatW-1:0] LatMax = LatW'(99999999);
  localparam logic [LonW-1:0] LonMax = LonW'(999999999);

  localparam logic [IdxW-1:0] HdrLen   = 3'd7;
  localparam logic [2:0]      FieldSat = 3'd7;
  localparam logic [2:0]      FieldStatus = 3'd2;
  localparam logic [2:0]      FieldLat    = 3'd3;
  localparam logic [2:0]      FieldAfterLat = 3'd4;
  localparam logic [2:0]      FieldLon    = 3'd5;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChP      = 8'h50;
  localparam logic [7:0] ChR      = 8'h52;
  localparam logic [7:0] ChM      = 8'h4D;
  localparam logic [7:0] ChC      = 8'h43;

  function automatic logic [7:0] hdr_char(input logic [IdxW-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0: ch = ChDollar;
      3'd1: ch = ChG;
      3'd2: ch = ChP;
      3'd3: ch = ChR;
      3'd4: ch = ChM;
      3'd5: ch = ChC;
      3'd6: ch = ChComma;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [Pow10W-1:0] pow10(input logic [FracW-1:0] k);
    logic [Pow10W-1:0] p;
    unique case (k)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

// File: src/nrpe_scale.sv
// Pads a converted number with missing fraction digits and saturates it.
module nrpe_scale import nrpe_pkg::*; #(
  parameter int unsigned W           = 30,
  parameter logic [W-1:0] MAX        = '1,
  parameter int unsigned FRAC_DIGITS = 4
) (
  input  logic [W-1:0]     acc_i,
  input  logic [FracW-1:0] frac_digits_i,
  output logic [W-1:0]     value_o
);

  localparam logic [FracW-1:0] FracMax = FracW'(FRAC_DIGITS);

  logic [FracW-1:0]    pad;
  logic [W+Pow10W-1:0] product;

  assign pad     = (frac_digits_i < FracMax) ? FracMax - frac_digits_i : '0;
  assign product = {{Pow10W{1'b0}}, acc_i} * {{W{1'b0}}, pow10(pad)};
  assign value_o = (product > {{Pow10W{1'b0}}, MAX}) ? MAX : product[W-1:0];

endmodule

// File: src/nmea_rmc_position_extractor_top.sv
// Top level of the RMC sentence parser: header match, field tracking, number conversion.
//
//  channel   dir  fields (tdata/tuser)
//  s_axis    in   tdata[7:0] rx_byte
//  m_axis    out  tdata[26:0] latitude_e4, tdata[56:27] longitude_e4; tuser fix_valid
//
//  One character per cycle while s_axis_tready_o is high; the parser state updates on the accept edge.
//  A result enters the output register at the accept of '*' and is shown the next cycle.
//  Input is taken while the output register is empty or being drained.
//  Reset clears all parser state and the output valid flag (not the output data); no clearing pass.
module nmea_rmc_position_extractor_top import nrpe_pkg::*; #(
  parameter int unsigned FRAC_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [26:0] latitude_e4, [56:27] longitude_e4, rest zero
  output logic        m_axis_tuser_o    // [0] fix_valid
);

  localparam logic [FracW-1:0] FracMax = FracW'(FRAC_DIGITS);

  logic [IdxW-1:0]  hdr_idx_q, hdr_idx_d;
  logic             in_sent_q, in_sent_d;
  logic [2:0]       field_q, field_d;
  logic             has_chars_q, has_chars_d;
  logic             status_q, status_d;
  logic             lon_done_q, lon_done_d;
  logic             in_frac_q, in_frac_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic             stopped_q, stopped_d;
  logic [LatW-1:0]  lat_q, lat_d;
  logic [LonW-1:0]  lon_q, lon_d;

  logic             out_valid_q, out_valid_d;
  logic             out_fix_q, out_fix_d;
  logic [LatW-1:0]  out_lat_q, out_lat_d;
  logic [LonW-1:0]  out_lon_q, out_lon_d;

  logic             accept;
  logic             load;
  logic [7:0]       ch;
  logic [3:0]       digit;
  logic             is_digit;
  logic [LatW-1:0]  lat_fin;
  logic [LonW-1:0]  lon_fin;
  logic [LatW+3:0]  lat_step;
  logic [LonW+3:0]  lon_step;

  assign ch       = s_axis_tdata_i;
  assign digit    = 4'(ch - ChZero);
  assign is_digit = (ch >= ChZero) && (ch <= ChNine);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  nrpe_scale #(.W(LatW), .MAX(LatMax), .FRAC_DIGITS(FRAC_DIGITS)) u_lat_scale (
    .acc_i        (lat_q),
    .frac_digits_i(frac_q),
    .value_o      (lat_fin)
  );

  nrpe_scale #(.W(LonW), .MAX(LonMax), .FRAC_DIGITS(FRAC_DIGITS)) u_lon_scale (
    .acc_i        (lon_q),
    .frac_digits_i(frac_q),
    .value_o      (lon_fin)
  );

  always_comb begin
    logic skip;
    hdr_idx_d   = hdr_idx_q;
    in_sent_d   = in_sent_q;
    field_d     = field_q;
    has_chars_d = has_chars_q;
    status_d    = status_q;
    lon_done_d  = lon_done_q;
    in_frac_d   = in_frac_q;
    frac_d      = frac_q;
    stopped_d   = stopped_q;
    lat_d       = lat_q;
    lon_d       = lon_q;
    load        = 1'b0;
    skip        = 1'b0;
    lat_step    = '0;
    lon_step    = '0;

    if (accept) begin
      if (!in_sent_q) begin
        if (hdr_idx_q < HdrLen && ch == hdr_char(hdr_idx_q)) begin
          hdr_idx_d = hdr_idx_q + 3'd1;
          if (hdr_idx_d == HdrLen) begin
            hdr_idx_d   = '0;
            in_sent_d   = 1'b1;
            field_d     = '0;
            has_chars_d = 1'b0;
            status_d    = 1'b0;
            lon_done_d  = 1'b0;
            in_frac_d   = 1'b0;
            frac_d      = '0;
            stopped_d   = 1'b0;
            lat_d       = '0;
            lon_d       = '0;
          end
        end else begin
          hdr_idx_d = (ch == ChDollar) ? 3'd1 : 3'd0;
        end
      end else if (ch == ChStar) begin
        load      = 1'b1;
        in_sent_d = 1'b0;
        hdr_idx_d = '0;
      end else if (ch == ChComma) begin
        has_chars_d = 1'b0;
        stopped_d   = 1'b1;
      end else if (!(field_q >= FieldStatus && !status_q)) begin
        // start of a new token
        if (!has_chars_q) begin
          if (lon_done_q) begin
            skip = 1'b1;
          end else begin
            has_chars_d = 1'b1;
            if (field_q < FieldSat) field_d = field_q + 3'd1;
            if (field_d == FieldAfterLat) lat_d = lat_fin;
            in_frac_d = 1'b0;
            frac_d    = '0;
            stopped_d = 1'b0;
            if (field_d == FieldStatus) begin
              status_d = (ch == ChA);
              skip     = 1'b1;
            end
            if (field_d == FieldLat) lat_d = '0;
            if (field_d == FieldLon) begin
              lon_d      = '0;
              lon_done_d = 1'b1;
            end
          end
        end
        if (!skip && !stopped_d && (field_d == FieldLat || field_d == FieldLon)) begin
          if (is_digit) begin
            if (!(in_frac_d && frac_d >= FracMax)) begin
              if (in_frac_d) frac_d = frac_d + 3'd1;
              lat_step = {4'd0, lat_d} * (LatW+4)'(10) + (LatW+4)'(digit);
              lon_step = {4'd0, lon_d} * (LonW+4)'(10) + (LonW+4)'(digit);
              if (field_d == FieldLat) begin
                lat_d = (lat_step > {4'd0, LatMax}) ? LatMax : lat_step[LatW-1:0];
              end else begin
                lon_d = (lon_step > {4'd0, LonMax}) ? LonMax : lon_step[LonW-1:0];
              end
            end
          end else if (ch == ChDot && !in_frac_d) begin
            in_frac_d = 1'b1;
          end else begin
            stopped_d = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_fix_d   = out_fix_q;
    out_lat_d   = out_lat_q;
    out_lon_d   = out_lon_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (load) begin
      out_valid_d = 1'b1;
      out_fix_d   = status_q && lon_done_q;
      out_lat_d   = out_fix_d ? lat_q : '0;
      out_lon_d   = out_fix_d ? lon_fin : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q   <= '0;
      in_sent_q   <= 1'b0;
      field_q     <= '0;
      has_chars_q <= 1'b0;
      status_q    <= 1'b0;
      lon_done_q  <= 1'b0;
      in_frac_q   <= 1'b0;
      frac_q      <= '0;
      stopped_q   <= 1'b0;
      lat_q       <= '0;
      lon_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_idx_q   <= hdr_idx_d;
      in_sent_q   <= in_sent_d;
      field_q     <= field_d;
      has_chars_q <= has_chars_d;
      status_q    <= status_d;
      lon_done_q  <= lon_done_d;
      in_frac_q   <= in_frac_d;
      frac_q      <= frac_d;
      stopped_q   <= stopped_d;
      lat_q       <= lat_d;
      lon_q       <= lon_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_fix_q <= out_fix_d;
    out_lat_q <= out_lat_d;
    out_lon_q <= out_lon_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_fix_q;
  assign m_axis_tdata_o  = {{(64-LatW-LonW){1'b0}}, out_lon_q, out_lat_q};

  a_hdr_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_idx_q < HdrLen) else $error("header index out of range");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_q <= FracMax) else $error("fraction digit count exceeds limit");

  a_lon_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lon_done_q |-> field_q == FieldLon) else $error("longitude flag without field five");

  a_status_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q |-> field_q >= FieldStatus) else $error("status set before status field");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (out_lat_q == '0 && out_lon_q == '0))
    else $error("invalid fix carries nonzero position");

endmodule

// File: tb/sv/tb_nmea_rmc_position_extractor_top.sv
// Self-checking testbench for the RMC position extractor: directed sentences, then random traffic.
module tb_nmea_rmc_position_extractor_top;
  import nrpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracDigits  = 4;
  localparam int          RandomItems = 1225;
  localparam int          StallLimit  = 2000;
  localparam int          NumRows     = 16;
  localparam string       RmcHeader   = "$GPRMC,";

  typedef struct packed {
    logic            fix;
    logic [LatW-1:0] lat;
    logic [LonW-1:0] lon;
  } fix_t;

  typedef struct {
    string text;
    bit    pinned;
    fix_t  want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  nmea_rmc_position_extractor_top #(
    .FRAC_DIGITS(FracDigits)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // parser state mirror
  logic [IdxW-1:0] hdr_pos;
  bit              in_rmc;
  logic [2:0]      tok_count;
  bit              tok_open;
  bit              status_a;
  bit              lon_seen;
  bit              after_dot;
  int unsigned     frac_kept;
  bit              conv_halted;
  logic [LatW-1:0] lat_acc;
  logic [LonW-1:0] lon_acc;

  fix_t        pending_fixes[$];
  int          mismatch_count;
  bit          in_quiet;
  bit          out_quiet;
  logic [7:0]  tx_bytes[$];

  dir_row_t dir_rows [NumRows] = '{
    '{"$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A",
      1'b1, '{1'b1, 27'd48070380, 30'd11310000}},
    '{"$GPRMC,123519,V,4807.038,N,01131.000,E*7D", 1'b1, '{1'b0, 27'd0, 30'd0}},
    '{"$GPRMC,1,A,9999999999,N,99999999999,E*00",
      1'b1, '{1'b1, 27'd99999999, 30'd999999999}},
    '{"$GPRMC,0,A,0,N,0,E*00", 1'b1, '{1'b1, 27'd0, 30'd0}},
    '{"$GPRMC,1,A,4807.038,N*00", 1'b1, '{1'b0, 27'd0, 30'd0}},
    '{"$GPRMC,*00", 1'b1, '{1'b0, 27'd0, 30'd0}},
    '{"$GPRMC,,A,,1234.5678,N,,00123.4567,E*00", 1'b0, '0},
    '{"$GPRMC,1,,A,,0100.12345,,N,0200.5,W*00", 1'b0, '0},
    '{"$GP$GPRMC,2,Active,-12.5,N,12.3.4,E*00", 1'b0, '0},
    '{"$$GPRMC,1,A,1.1,N,2.2,E*00", 1'b0, '0},
    '{"$GPGGA,1,A,1,N,2,E*00", 1'b0, '0},
    '{"$GPRMC,1,A,12 34,N,1$2,E", 1'b0, '0},
    '{"$GPRMC,1,A,5,N,6,E*00", 1'b0, '0},
    '{"$GPRMC,1,a,5,N,6,E*00", 1'b0, '0},
    '{"$GPRMC,1,A,12.,N,123456.7654321,E,x,y,z,*00", 1'b0, '0},
    '{"$GPRMC,1,A,.5,N,99999.99999,E,1,2,3,4,5,6,7,8*00", 1'b0, '0}
  };

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_sentence();
    tok_count   = '0;
    tok_open    = 1'b0;
    status_a    = 1'b0;
    lon_seen    = 1'b0;
    after_dot   = 1'b0;
    frac_kept   = 0;
    conv_halted = 1'b0;
    lat_acc     = '0;
    lon_acc     = '0;
  endfunction

  function automatic logic [63:0] push_digit(input logic [63:0] acc, input logic [63:0] d,
                                             input logic [63:0] max_val);
    logic [63:0] v;
    v = acc * 10 + d;
    return (v > max_val) ? max_val : v;
  endfunction

  // pad a short fraction with zeros up to the fixed scale
  function automatic logic [63:0] scale_frac(input logic [63:0] acc, input logic [63:0] max_val);
    logic [63:0] v;
    int          k;
    v = acc;
    k = (frac_kept < FracDigits) ? FracDigits - frac_kept : 0;
    repeat (k) v = v * 10;
    return (v > max_val) ? max_val : v;
  endfunction

  task automatic parse_char(input logic [7:0] c, input bit pinned, input fix_t pin_val);
    fix_t res;
    bit   ok;
    if (!in_rmc) begin
      if (hdr_pos < HdrLen && c == RmcHeader[hdr_pos]) begin
        hdr_pos = hdr_pos + 1'b1;
        if (hdr_pos == HdrLen) begin
          hdr_pos = '0;
          in_rmc  = 1'b1;
          clear_sentence();
        end
      end else begin
        hdr_pos = (c == ChDollar) ? IdxW'(1) : '0;
      end
      return;
    end
    if (c == ChStar) begin
      ok      = status_a && lon_seen;
      res.fix = ok;
      res.lat = ok ? lat_acc : '0;
      res.lon = ok ? LonW'(scale_frac(64'(lon_acc), 64'(LonMax))) : '0;
      pending_fixes.push_back(pinned ? pin_val : res);
      in_rmc  = 1'b0;
      hdr_pos = '0;
      return;
    end
    if (c == ChComma) begin
      tok_open    = 1'b0;
      conv_halted = 1'b1;
      return;
    end
    if (tok_count >= FieldStatus && !status_a) return;
    if (!tok_open) begin
      if (lon_seen) return;
      tok_open = 1'b1;
      if (tok_count < FieldSat) tok_count = tok_count + 1'b1;
      if (tok_count == FieldAfterLat) lat_acc = LatW'(scale_frac(64'(lat_acc), 64'(LatMax)));
      after_dot   = 1'b0;
      frac_kept   = 0;
      conv_halted = 1'b0;
      if (tok_count == FieldStatus) begin
        status_a = (c == ChA);
        return;
      end
      if (tok_count == FieldLat) lat_acc = '0;
      if (tok_count == FieldLon) begin
        lon_acc  = '0;
        lon_seen = 1'b1;
      end
    end
    if (conv_halted || (tok_count != FieldLat && tok_count != FieldLon)) return;
    if (c >= ChZero && c <= ChNine) begin
      if (after_dot) begin
        if (frac_kept >= FracDigits) return;
        frac_kept++;
      end
      if (tok_count == FieldLat) begin
        lat_acc = LatW'(push_digit(64'(lat_acc), 64'(c - ChZero), 64'(LatMax)));
      end else begin
        lon_acc = LonW'(push_digit(64'(lon_acc), 64'(c - ChZero), 64'(LonMax)));
      end
    end else if (c == ChDot && !after_dot) begin
      after_dot = 1'b1;
    end else begin
      conv_halted = 1'b1;
    end
  endtask

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_char(input logic [7:0] c, input bit pinned, input fix_t pin_val);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_char(c, pinned, pin_val);
    gap = in_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endfunction

  function automatic void add_number();
    int n_int;
    int n_frac;
    bit nines;
    n_int = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
    nines = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 19))
      0: add_text("-");
      1: add_text(" ");
      default: ;
    endcase
    repeat (n_int) tx_bytes.push_back(nines ? ChNine : 8'(ChZero + $urandom_range(0, 9)));
    if ($urandom_range(0, 4) != 0) begin
      tx_bytes.push_back(ChDot);
      n_frac = $urandom_range(0, 7);
      repeat (n_frac) tx_bytes.push_back(nines ? ChNine : 8'(ChZero + $urandom_range(0, 9)));
      if ($urandom_range(0, 14) == 0) add_text(".7");
    end
  endfunction

  task automatic gen_sentence();
    int r;
    tx_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 12)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (r < 12) add_text("$GPGGA,");
    else if (r < 16) add_text("$G$GPRMC,");
    else add_text("$GPRMC,");
    if ($urandom_range(0, 4) != 0) add_number();
    add_text(",");
    if ($urandom_range(0, 9) == 0) add_text(",");
    r = $urandom_range(0, 99);
    if (r < 80) add_text("A");
    else if (r < 88) add_text("V");
    else if (r < 94) add_text("A1");
    else tx_bytes.push_back(8'($urandom_range(0, 255)));
    add_text(",");
    if ($urandom_range(0, 9) == 0) add_text(",");
    add_number();
    add_text($urandom_range(0, 1) ? ",N," : ",S,");
    if ($urandom_range(0, 9) == 0) add_text(",");
    add_number();
    add_text($urandom_range(0, 1) ? ",E" : ",W");
    if ($urandom_range(0, 2) == 0) add_text(",022.4,084.4,230394,003.1,W");
    if ($urandom_range(0, 9) == 0) begin
      tx_bytes[$urandom_range(0, tx_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 11) != 0) add_text("*4F");
  endtask

  // result side: check and stall
  always @(posedge clk_i) begin : result_side
    fix_t want;
    int   stall_left;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_fixes.size() == 0) begin
        note_mismatch("result with nothing pending", m_axis_tdata_o, 0);
      end else begin
        want = pending_fixes.pop_front();
        if (m_axis_tuser_o !== want.fix) note_mismatch("fix_valid", m_axis_tuser_o, want.fix);
        if (m_axis_tdata_o[26:0] !== want.lat) begin
          note_mismatch("latitude_e4", m_axis_tdata_o[26:0], want.lat);
        end
        if (m_axis_tdata_o[56:27] !== want.lon) begin
          note_mismatch("longitude_e4", m_axis_tdata_o[56:27], want.lon);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      stall_left = out_quiet ? 0 : pick_gap();
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) idle = 0;
      else idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int bytes_sent;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    hdr_pos         = '0;
    in_rmc          = 1'b0;
    clear_sentence();
    mismatch_count  = 0;
    in_quiet        = 1'b0;
    out_quiet       = 1'b0;
    bytes_sent      = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].text.len(); i++) begin
        send_char(dir_rows[r].text[i], dir_rows[r].pinned, dir_rows[r].want);
      end
    end

    while (bytes_sent < RandomItems) begin
      gen_sentence();
      if ($urandom_range(0, 5) == 0) in_quiet = !in_quiet;
      if ($urandom_range(0, 5) == 0) out_quiet = !out_quiet;
      foreach (tx_bytes[i]) send_char(tx_bytes[i], 1'b0, '0);
      bytes_sent += tx_bytes.size();
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
src/nrpe_pkg.sv
src/nrpe_scale.sv
src/nmea_rmc_position_extractor_top.sv
tb/sv/tb_nmea_rmc_position_extractor_top.sv
